>>> hdl/fircv_pkg.sv
// ----------------------------------------------------------------------------
// fircv_pkg
// Shared sizes and the wave type that runs down the tap chain of the
// FIR convolver.
// ----------------------------------------------------------------------------
`default_nettype none

package fircv_pkg;

    // number of taps, one cell each
    localparam int TAPS    = 64;
    localparam int IDX_W   = (TAPS > 1) ? $clog2(TAPS) : 1;
    // sample and coefficient width, Q1.15
    localparam int DATA_W  = 16;
    localparam int PROD_W  = 2 * DATA_W;
    // Q2.30 products summed over all taps
    localparam int ACC_W   = PROD_W + IDX_W;
    // width that holds a tap position, the tap count and the load index
    localparam int SEL_W   = (IDX_W + 1 > 7) ? IDX_W + 1 : 7;
    localparam int CNT_W   = 7;
    localparam int INDEX_W = 6;

    // input kinds carried in tuser
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_FEED = 1'b1;

    // partial sum travelling from cell to cell with its marker
    typedef struct packed {
        logic                    valid;
        logic signed [ACC_W-1:0] sum;
    } t_wave;

endpackage

`default_nettype wire

>>> hdl/fircv_cell.sv
// ----------------------------------------------------------------------------
// fircv_cell
// One tap: holds a coefficient and a history sample, shifts the history to
// its neighbor and adds its product to the passing partial sum.
// ----------------------------------------------------------------------------
`default_nettype none

module fircv_cell (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_shift,
    input  wire logic signed [fircv_pkg::DATA_W-1:0]  i_hist,
    output logic signed      [fircv_pkg::DATA_W-1:0]  o_hist,
    input  wire logic                                 i_coef_we,
    input  wire logic signed [fircv_pkg::DATA_W-1:0]  i_coef,
    input  wire logic                                 i_active,
    input  wire fircv_pkg::t_wave                     i_wave,
    output fircv_pkg::t_wave                          o_wave
);

    logic signed [fircv_pkg::DATA_W-1:0] r_hist;
    logic signed [fircv_pkg::DATA_W-1:0] r_coef;
    logic                                r_valid;
    logic signed [fircv_pkg::ACC_W-1:0]  r_sum;
    logic signed [fircv_pkg::PROD_W-1:0] w_prod;
    logic signed [fircv_pkg::ACC_W-1:0]  w_term;

    // tap product, dropped for taps beyond the count in use
    assign w_prod = r_coef * r_hist;
    assign w_term = i_active
        ? {{(fircv_pkg::ACC_W - fircv_pkg::PROD_W){w_prod[fircv_pkg::PROD_W-1]}}, w_prod}
        : '0;

    // history line and coefficient store
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist <= '0;
            r_coef <= '0;
        end else begin
            if (i_shift) begin
                r_hist <= i_hist;
            end
            if (i_coef_we) begin
                r_coef <= i_coef;
            end
        end
    end

    // marker of the partial sum
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_wave.valid;
        end
    end

    // partial sum
    always_ff @(posedge i_clk) begin
        r_sum <= i_wave.sum + w_term;
    end

    assign o_hist       = r_hist;
    assign o_wave.valid = r_valid;
    assign o_wave.sum   = r_sum;

endmodule

`default_nettype wire

>>> hdl/fir_convolver.sv
// ----------------------------------------------------------------------------
// fir_convolver
// Direct-form FIR convolution of a mono Q1.15 stream with a loaded impulse
// response, built as a chain of tap cells.
// ----------------------------------------------------------------------------
// A load transfer (tuser = 0) writes one coefficient. A feed transfer
// (tuser = 1) shifts the sample into the history line and sends a partial
// sum down the chain of TAPS cells, one cell per cycle, each adding its
// coefficient times its history sample when it lies within tap_count.
// The sum is floor-shifted by 15 and saturated to 16 bits, with tuser
// flagging a clipped result. A feed holds the input off while its sum walks
// through the cells and until it enters the output register; the next
// transfer is taken while the result still waits there. The user must write
// tap_count via i_cfg_wen / i_cfg_wdata while idle; the block won't enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module fir_convolver (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration: tap_count
    input  wire logic        i_cfg_wen,
    input  wire logic [6:0]  i_cfg_wdata,
    // input stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // tap_index[5:0], value[21:6], zero pad
    input  wire logic        s_axis_tuser,   // func[0]
    // output stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // sample_out[15:0]
    output logic             m_axis_tuser    // clipped[0]
);

    localparam int TAPS   = fircv_pkg::TAPS;
    localparam int DATA_W = fircv_pkg::DATA_W;
    localparam int ACC_W  = fircv_pkg::ACC_W;
    localparam int SEL_W  = fircv_pkg::SEL_W;

    logic [fircv_pkg::CNT_W-1:0]   r_tap_count;
    logic                          r_busy;
    logic                          r_start;
    logic                          r_sum_valid;
    logic signed [ACC_W-1:0]       r_sum;
    logic                          r_out_valid;
    logic [DATA_W-1:0]             r_out_sample;
    logic                          r_out_clip;

    logic                          w_in_fire;
    logic                          w_feed;
    logic                          w_load;
    logic                          w_out_load;
    logic [fircv_pkg::INDEX_W-1:0] w_tap_index;
    logic signed [DATA_W-1:0]      w_value;
    logic signed [DATA_W-1:0]      w_hist [0:TAPS];
    fircv_pkg::t_wave              w_wave [0:TAPS];
    logic [TAPS-1:0]               w_tok;
    logic [ACC_W-31:0]             w_hi;
    logic                          w_clip;
    logic [DATA_W-1:0]             w_sample;

    // input unpack and transfer decode
    assign w_tap_index   = s_axis_tdata[5:0];
    assign w_value       = s_axis_tdata[21:6];
    assign s_axis_tready = !r_busy;
    assign w_in_fire     = s_axis_tvalid && s_axis_tready;
    assign w_feed        = w_in_fire && (s_axis_tuser == fircv_pkg::FUNC_FEED);
    assign w_load        = w_in_fire && (s_axis_tuser == fircv_pkg::FUNC_LOAD);

    // tap count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap_count <= 7'd64;
        end else if (i_cfg_wen) begin
            r_tap_count <= i_cfg_wdata;
        end
    end

    // head of the chain: fresh sample and an empty sum
    assign w_hist[0]      = w_value;
    assign w_wave[0].valid = r_start;
    assign w_wave[0].sum   = '0;

    // tap cells
    for (genvar k = 0; k < TAPS; k++) begin : g_cell
        logic w_active;
        logic w_coef_we;

        assign w_active  = SEL_W'(k) < SEL_W'(r_tap_count);
        assign w_coef_we = w_load && (SEL_W'(w_tap_index) == SEL_W'(k));
        assign w_tok[k]  = w_wave[k+1].valid;

        fircv_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_shift   (w_feed),
            .i_hist    (w_hist[k]),
            .o_hist    (w_hist[k+1]),
            .i_coef_we (w_coef_we),
            .i_coef    (w_value),
            .i_active  (w_active),
            .i_wave    (w_wave[k]),
            .o_wave    (w_wave[k+1])
        );
    end

    // sequencing: busy from a feed until its sum reaches the output register
    assign w_out_load = r_sum_valid && (!r_out_valid || m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_start     <= 1'b0;
            r_sum_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_start <= w_feed;
            if (w_feed) begin
                r_busy <= 1'b1;
            end else if (w_out_load) begin
                r_busy <= 1'b0;
            end
            if (w_wave[TAPS].valid) begin
                r_sum_valid <= 1'b1;
            end else if (w_out_load) begin
                r_sum_valid <= 1'b0;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // finished sum from the chain tail
    always_ff @(posedge i_clk) begin
        if (w_wave[TAPS].valid) begin
            r_sum <= w_wave[TAPS].sum;
        end
    end

    // floor shift by 15 and saturation: clipped when bits above Q1.15 disagree
    assign w_hi     = r_sum[ACC_W-1:30];
    assign w_clip   = !((&w_hi) || !(|w_hi));
    assign w_sample = w_clip ? (r_sum[ACC_W-1] ? 16'h8000 : 16'h7FFF) : r_sum[30:15];

    // output register
    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_sample <= w_sample;
            r_out_clip   <= w_clip;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_sample;
    assign m_axis_tuser  = r_out_clip;

    // at most one sum in flight between the chain head and the hold register
    a_one_wave: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_tok, r_start, r_sum_valid}))
        else $error("more than one partial sum in flight");

    // a held sum always belongs to a feed that still blocks the input
    a_sum_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sum_valid |-> r_busy)
        else $error("finished sum held while not busy");

    // the hold register fills only from the chain tail
    a_sum_from_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_sum_valid) |-> $past(w_wave[TAPS].valid))
        else $error("sum appeared without leaving the last cell");

endmodule

`default_nettype wire
